FILE: src/voxel_boundary_quads_defines.svh
// ---------------------------------------------------------------------------
// voxel_boundary_quads_defines.svh
// Assertion macros shared by the voxel boundary quad block.
// ---------------------------------------------------------------------------
`ifndef VOXEL_BOUNDARY_QUADS_DEFINES_SVH
`define VOXEL_BOUNDARY_QUADS_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during rst
`define VBQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, sampled on clk, off during rst
`define VBQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define VBQ_ASSERT_IMP(lbl, ante, cons, msg)
`define VBQ_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

FILE: src/vbq_pkg.sv
// ---------------------------------------------------------------------------
// vbq_pkg
// Types and constants of the voxel boundary quad block.
// ---------------------------------------------------------------------------
`default_nettype none

package vbq_pkg;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  // input operation codes
  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_EXAMINE = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_TARGET = 2'd0;
  localparam logic [1:0] CFG_SIZE_X = 2'd1;
  localparam logic [1:0] CFG_SIZE_Y = 2'd2;
  localparam logic [1:0] CFG_SIZE_Z = 2'd3;

  // face directions
  localparam logic [2:0] DIR_NEG_X = 3'd0;
  localparam logic [2:0] DIR_POS_X = 3'd1;
  localparam logic [2:0] DIR_NEG_Y = 3'd2;
  localparam logic [2:0] DIR_POS_Y = 3'd3;
  localparam logic [2:0] DIR_NEG_Z = 3'd4;
  localparam logic [2:0] DIR_POS_Z = 3'd5;

  // read sequence steps: center first, then one neighbor per direction
  localparam logic [2:0] STEP_CENTER = 3'd0;
  localparam logic [2:0] STEP_NEG_X  = 3'd1;
  localparam logic [2:0] STEP_POS_X  = 3'd2;
  localparam logic [2:0] STEP_NEG_Y  = 3'd3;
  localparam logic [2:0] STEP_POS_Y  = 3'd4;
  localparam logic [2:0] STEP_NEG_Z  = 3'd5;
  localparam logic [2:0] STEP_POS_Z  = 3'd6;
  localparam logic [2:0] STEP_LAST   = 3'd7;

  localparam logic [17:0] FACE_LIMIT = 18'd196607;

endpackage

`default_nettype wire

FILE: src/voxel_boundary_quads.sv
// ---------------------------------------------------------------------------
// voxel_boundary_quads
// Labelled voxel grid with face culling: emits boundary quads per voxel.
// ---------------------------------------------------------------------------
// A write leaves the block idle and ready for the next item. An
// examine of a voxel inside the extent in use walks the single read port of
// the label memory over seven reads (center, then -x,+x,-y,+y,-z,+z), with
// one shared label comparator judging each read in the step after it, so the
// block is busy until the last read is judged. If the center holds the target
// label, it then emits one face per bare side, one per cycle while the output
// is not stalled, and takes the next item. An examine outside the extent
// reads nothing and emits nothing. The last face of an examine is still in
// the output register when the next item may be taken. The label memory has
// no reset; never read a voxel that was not written.
`default_nettype none

`include "voxel_boundary_quads_defines.svh"

module voxel_boundary_quads
  import vbq_pkg::*;
#(
  parameter int GRID_X     = 32,
  parameter int GRID_Y     = 32,
  parameter int GRID_Z     = 32,
  parameter int LABEL_BITS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // item channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        operation,
  input  wire logic [4:0]  pos_x,
  input  wire logic [4:0]  pos_y,
  input  wire logic [4:0]  pos_z,
  input  wire logic [7:0]  label,
  // face channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [4:0]       face_x,
  output logic [4:0]       face_y,
  output logic [4:0]       face_z,
  output logic [2:0]       face_dir,
  output logic [17:0]      face_number,
  output logic             run_end,
  // configuration channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  // coordinates are 5 bits, so no axis needs more than 5 address bits
  localparam int AXW_X  = (GRID_X >= 32) ? 5 : ((GRID_X > 1) ? $clog2(GRID_X) : 1);
  localparam int AXW_Y  = (GRID_Y >= 32) ? 5 : ((GRID_Y > 1) ? $clog2(GRID_Y) : 1);
  localparam int AXW_Z  = (GRID_Z >= 32) ? 5 : ((GRID_Z > 1) ? $clog2(GRID_Z) : 1);
  localparam int ADDR_W = AXW_X + AXW_Y + AXW_Z;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int CMP_W  = (LABEL_BITS > 8) ? LABEL_BITS : 8;

  // configuration
  logic [7:0] target_label;
  logic [5:0] size_x;
  logic [5:0] size_y;
  logic [5:0] size_z;

  // control
  state_t      state;
  logic [2:0]  step;
  logic [17:0] face_count;
  logic [4:0]  cur_x;
  logic [4:0]  cur_y;
  logic [4:0]  cur_z;
  logic [5:0]  at_edge;
  logic [5:0]  side;
  logic [5:0]  side_next;
  logic        center_hit;

  // label memory
  logic [LABEL_BITS-1:0] mem [DEPTH];
  logic [LABEL_BITS-1:0] rd_data;
  logic [ADDR_W-1:0]     rd_addr;
  logic [ADDR_W-1:0]     wr_addr;
  logic                  rd_en;
  logic                  wr_en;
  logic [CMP_W-1:0]      label_ext;
  logic                  lab_match;

  logic [8:0] ext_x;
  logic [8:0] ext_y;
  logic [8:0] ext_z;
  logic [8:0] px;
  logic [8:0] py;
  logic [8:0] pz;
  logic       in_fire;
  logic       in_extent;
  logic       in_grid;
  logic       emit_fire;
  logic [4:0] nx;
  logic [4:0] ny;
  logic [4:0] nz;
  logic [2:0] eval_idx;
  logic [5:0] low_bit;
  logic [5:0] side_rest;
  logic [2:0] low_dir;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_label <= 8'd0;
      size_x       <= 6'd32;
      size_y       <= 6'd32;
      size_z       <= 6'd32;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TARGET: target_label <= cfg_data;
        CFG_SIZE_X: size_x       <= cfg_data[5:0];
        CFG_SIZE_Y: size_y       <= cfg_data[5:0];
        CFG_SIZE_Z: size_z       <= cfg_data[5:0];
        default:    ;
      endcase
    end
  end

  // extent in use: smaller of size register and grid
  assign ext_x = ({3'd0, size_x} < 9'(GRID_X)) ? {3'd0, size_x} : 9'(GRID_X);
  assign ext_y = ({3'd0, size_y} < 9'(GRID_Y)) ? {3'd0, size_y} : 9'(GRID_Y);
  assign ext_z = ({3'd0, size_z} < 9'(GRID_Z)) ? {3'd0, size_z} : 9'(GRID_Z);

  assign px = {4'd0, pos_x};
  assign py = {4'd0, pos_y};
  assign pz = {4'd0, pos_z};

  assign in_extent = (px < ext_x) && (py < ext_y) && (pz < ext_z);
  assign in_grid   = (px < 9'(GRID_X)) && (py < 9'(GRID_Y)) && (pz < 9'(GRID_Z));

  // write port
  assign wr_en     = in_fire && (operation == OP_WRITE) && in_grid;
  assign wr_addr   = {pos_x[AXW_X-1:0], pos_y[AXW_Y-1:0], pos_z[AXW_Z-1:0]};
  assign label_ext = CMP_W'(label);

  // read address walks center, then the six neighbors; edge reads are ignored
  always_comb begin
    nx = cur_x;
    ny = cur_y;
    nz = cur_z;
    unique case (step)
      STEP_NEG_X: nx = cur_x - 5'd1;
      STEP_POS_X: nx = cur_x + 5'd1;
      STEP_NEG_Y: ny = cur_y - 5'd1;
      STEP_POS_Y: ny = cur_y + 5'd1;
      STEP_NEG_Z: nz = cur_z - 5'd1;
      STEP_POS_Z: nz = cur_z + 5'd1;
      default:    ;
    endcase
  end

  assign rd_addr = {nx[AXW_X-1:0], ny[AXW_Y-1:0], nz[AXW_Z-1:0]};
  assign rd_en   = (state == ST_READ) && (step != STEP_LAST);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= label_ext[LABEL_BITS-1:0];
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // shared comparator: judges the read issued one step earlier
  assign lab_match = (CMP_W'(rd_data) == CMP_W'(target_label));
  assign eval_idx  = step - 3'd2;

  always_comb begin
    side_next = side;
    if (step > STEP_NEG_X) begin
      side_next[eval_idx] = at_edge[eval_idx] || !lab_match;
    end
  end

  // pick the lowest pending side
  assign low_bit   = side & (~side + 6'd1);
  assign side_rest = side & (side - 6'd1);

  always_comb begin
    priority case (1'b1)
      low_bit[0]: low_dir = DIR_NEG_X;
      low_bit[1]: low_dir = DIR_POS_X;
      low_bit[2]: low_dir = DIR_NEG_Y;
      low_bit[3]: low_dir = DIR_POS_Y;
      low_bit[4]: low_dir = DIR_NEG_Z;
      default:    low_dir = DIR_POS_Z;
    endcase
  end

  assign emit_fire = (state == ST_EMIT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      step       <= STEP_CENTER;
      face_count <= 18'd0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (operation == OP_WRITE) begin
              face_count <= 18'd0;
            end else if (in_extent) begin
              state <= ST_READ;
              step  <= STEP_CENTER;
            end
          end
        end
        ST_READ: begin
          step <= step + 3'd1;
          if (step == STEP_LAST) begin
            if (center_hit && (side_next != 6'd0)) begin
              state <= ST_EMIT;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_EMIT: begin
          if (emit_fire) begin
            if (face_count != FACE_LIMIT) begin
              face_count <= face_count + 18'd1;
            end
            if (side_rest == 6'd0) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // item capture and per-step results
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cur_x      <= pos_x;
      cur_y      <= pos_y;
      cur_z      <= pos_z;
      at_edge[0] <= (pos_x == 5'd0);
      at_edge[1] <= ((px + 9'd1) >= ext_x);
      at_edge[2] <= (pos_y == 5'd0);
      at_edge[3] <= ((py + 9'd1) >= ext_y);
      at_edge[4] <= (pos_z == 5'd0);
      at_edge[5] <= ((pz + 9'd1) >= ext_z);
    end
    if (state == ST_READ) begin
      side <= side_next;
      if (step == STEP_NEG_X) begin
        center_hit <= lab_match;
      end
    end else if (emit_fire) begin
      side <= side_rest;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      face_x      <= cur_x;
      face_y      <= cur_y;
      face_z      <= cur_z;
      face_dir    <= low_dir;
      face_number <= face_count;
      run_end     <= (side_rest == 6'd0);
    end
  end

  `VBQ_ASSERT_NXT(a_write_clears_count, in_fire && (operation == OP_WRITE), face_count == 18'd0, "face counter not cleared by write")
  `VBQ_ASSERT_NXT(a_face_numbered, emit_fire, out_valid && (face_number == $past(face_count)), "emitted face carries wrong number")
  `VBQ_ASSERT_IMP(a_emit_has_side, state == ST_EMIT, side != 6'd0, "emit state with no pending side")

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for voxel_boundary_quads. Runs directed cases, then
// random write/examine traffic under several register settings and idle
// patterns. Examine results rest only on written voxels. Every face is
// compared field by field with a behavioral face predictor.
// ---------------------------------------------------------------------------
module tb_top;
  import vbq_pkg::*;

  localparam int GRID           = 32;
  localparam int GRID_CELLS     = GRID * GRID * GRID;
  localparam int CYCLE_LIMIT    = 200_000;
  localparam int SETTLE_CYCLES  = 16;
  localparam int END_WAIT       = 10_000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 28;
  localparam int REPORT_LIMIT   = 10;
  localparam logic [7:0] DIRECTED_LABEL = 8'hA5;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [4:0]  x;
    logic [4:0]  y;
    logic [4:0]  z;
    logic [2:0]  dir;
    logic [17:0] number;
    logic        last;
  } face_t;

  class quad_scoreboard;
    logic [7:0]  labels [GRID_CELLS];
    bit          written [GRID_CELLS];
    logic [17:0] face_count = '0;
    logic [7:0]  target = '0;
    logic [5:0]  size_x = 6'd32;
    logic [5:0]  size_y = 6'd32;
    logic [5:0]  size_z = 6'd32;
    face_t       expected_faces [$];
    int          failures = 0;

    function int extent(logic [5:0] size);
      return (size < GRID) ? int'(size) : GRID;
    endfunction

    function int cell_index(logic [4:0] x, logic [4:0] y, logic [4:0] z);
      return (int'(x) * GRID + int'(y)) * GRID + int'(z);
    endfunction

    // neighbor coordinates wrap at five bits, like the ports
    function void neighbor(input logic [4:0] x, input logic [4:0] y, input logic [4:0] z,
                           input int d, output logic [4:0] nx, output logic [4:0] ny,
                           output logic [4:0] nz);
      nx = x;
      ny = y;
      nz = z;
      case (d)
        DIR_NEG_X: nx = x - 5'd1;
        DIR_POS_X: nx = x + 5'd1;
        DIR_NEG_Y: ny = y - 5'd1;
        DIR_POS_Y: ny = y + 5'd1;
        DIR_NEG_Z: nz = z - 5'd1;
        default:   nz = z + 5'd1;
      endcase
    endfunction

    // side lies on the wall of the extent in use
    function bit on_wall(logic [4:0] x, logic [4:0] y, logic [4:0] z, int d,
                         int ex, int ey, int ez);
      case (d)
        DIR_NEG_X: return (x == 5'd0);
        DIR_POS_X: return (int'(x) + 1 >= ex);
        DIR_NEG_Y: return (y == 5'd0);
        DIR_POS_Y: return (int'(y) + 1 >= ey);
        DIR_NEG_Z: return (z == 5'd0);
        default:   return (int'(z) + 1 >= ez);
      endcase
    endfunction

    function void set_register(logic [1:0] index, logic [7:0] data);
      case (index)
        CFG_TARGET: target = data;
        CFG_SIZE_X: size_x = data[5:0];
        CFG_SIZE_Y: size_y = data[5:0];
        default:    size_z = data[5:0];
      endcase
    endfunction

    // an examine here depends only on voxels that hold a label
    function bit examine_safe(logic [4:0] x, logic [4:0] y, logic [4:0] z);
      int         ex, ey, ez, d;
      logic [4:0] nx, ny, nz;
      ex = extent(size_x);
      ey = extent(size_y);
      ez = extent(size_z);
      if (x >= ex || y >= ey || z >= ez) return 1'b1;
      if (!written[cell_index(x, y, z)]) return 1'b0;
      if (labels[cell_index(x, y, z)] != target) return 1'b1;
      for (d = 0; d < 6; d++) begin
        neighbor(x, y, z, d, nx, ny, nz);
        if (!on_wall(x, y, z, d, ex, ey, ez) && !written[cell_index(nx, ny, nz)])
          return 1'b0;
      end
      return 1'b1;
    endfunction

    function void take_voxel_item(logic op, logic [4:0] x, logic [4:0] y, logic [4:0] z,
                                  logic [7:0] lab);
      int         ex, ey, ez, d, last_dir;
      logic [4:0] nx, ny, nz;
      bit         bare [6];
      face_t      f;
      if (op == OP_WRITE) begin
        labels[cell_index(x, y, z)]  = lab;
        written[cell_index(x, y, z)] = 1'b1;
        face_count = '0;
        return;
      end
      ex = extent(size_x);
      ey = extent(size_y);
      ez = extent(size_z);
      if (x >= ex || y >= ey || z >= ez) return;
      if (labels[cell_index(x, y, z)] != target) return;
      last_dir = -1;
      for (d = 0; d < 6; d++) begin
        neighbor(x, y, z, d, nx, ny, nz);
        bare[d] = on_wall(x, y, z, d, ex, ey, ez) ||
                  (labels[cell_index(nx, ny, nz)] != target);
        if (bare[d]) last_dir = d;
      end
      for (d = 0; d < 6; d++) begin
        if (bare[d]) begin
          f.x      = x;
          f.y      = y;
          f.z      = z;
          f.dir    = 3'(d);
          f.number = face_count;
          f.last   = (d == last_dir);
          expected_faces.insert(expected_faces.size(), f);
          // hold at the limit
          if (face_count < FACE_LIMIT) face_count++;
        end
      end
    endfunction

    function void note_failure(string what, face_t want, face_t seen);
      failures++;
      if (failures <= REPORT_LIMIT)
        $display("%s: expected %0d,%0d,%0d dir=%0d num=%0d end=%0b, got %0d,%0d,%0d %s",
                 what, want.x, want.y, want.z, want.dir, want.number, want.last,
                 seen.x, seen.y, seen.z,
                 $sformatf("dir=%0d num=%0d end=%0b", seen.dir, seen.number, seen.last));
    endfunction

    function void check_face(face_t seen);
      face_t want;
      if (expected_faces.size() == 0) begin
        note_failure("unexpected face", '0, seen);
        return;
      end
      want = expected_faces.pop_front();
      if (seen !== want) note_failure("face mismatch", want, seen);
    endfunction

    function void check_drained();
      if (expected_faces.size() != 0) begin
        failures++;
        $display("%0d expected faces never arrived", expected_faces.size());
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        operation = OP_WRITE;
  logic [4:0]  pos_x = '0;
  logic [4:0]  pos_y = '0;
  logic [4:0]  pos_z = '0;
  logic [7:0]  label = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [4:0]  face_x;
  logic [4:0]  face_y;
  logic [4:0]  face_z;
  logic [2:0]  face_dir;
  logic [17:0] face_number;
  logic        run_end;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_TARGET;
  logic [7:0]  cfg_data = '0;

  quad_scoreboard board;
  int             sender_gap_pct = 0;
  int             stall_pct = 0;
  int             items_sent = 0;
  int             cycle_count = 0;

  voxel_boundary_quads DUT (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin : face_monitor
    face_t seen;
    if (!rst && out_valid && out_ready) begin
      seen = {face_x, face_y, face_z, face_dir, face_number, run_end};
      board.check_face(seen);
    end
  end

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin sender_gap_pct = 0;  stall_pct = 0;  end
      IDLE_SENDER:   begin sender_gap_pct = 55; stall_pct = 0;  end
      IDLE_RECEIVER: begin sender_gap_pct = 0;  stall_pct = 55; end
      default:       begin sender_gap_pct = 26; stall_pct = 26; end
    endcase
  endtask

  task automatic send_item(input logic op, input logic [4:0] x, input logic [4:0] y,
                           input logic [4:0] z, input logic [7:0] lab);
    while ($urandom_range(99) < sender_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    pos_x     <= x;
    pos_y     <= y;
    pos_z     <= z;
    label     <= lab;
    do @(posedge clk); while (!in_ready);
    board.take_voxel_item(op, x, y, z, lab);
    items_sent++;
  endtask

  // drop valid until every face is out, then let a faceless examine finish
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.expected_faces.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [7:0] tgt, input logic [5:0] sx,
                                input logic [5:0] sy, input logic [5:0] sz);
    logic [1:0] idx [4];
    logic [7:0] val [4];
    logic [1:0] pad;
    int         i;
    wait_drained();
    pad = 2'($urandom);
    idx = '{CFG_TARGET, CFG_SIZE_X, CFG_SIZE_Y, CFG_SIZE_Z};
    // size registers keep only six bits; junk above them must not matter
    val = '{tgt, {pad, sx}, {2'b00, sy}, {pad, sz}};
    for (i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
      board.set_register(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [4:0] coord_in(logic [5:0] size);
    int ext;
    ext = board.extent(size);
    if (ext == 0 || $urandom_range(9) == 0) return 5'($urandom);
    return 5'($urandom_range(ext - 1));
  endfunction

  function automatic logic [5:0] pick_size();
    case ($urandom_range(9))
      0:       return 6'd1;
      1:       return 6'd32;
      2:       return 6'($urandom_range(63, 33));
      default: return 6'($urandom_range(32, 2));
    endcase
  endfunction

  function automatic logic [7:0] fill_label();
    case ($urandom_range(5))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'hC3;
      default: return 8'h3C;
    endcase
  endfunction

  // give every empty neighbor a fill label
  task automatic cover_neighbors(input logic [4:0] x, input logic [4:0] y,
                                 input logic [4:0] z);
    logic [4:0] nx, ny, nz;
    int         d;
    for (d = 0; d < 6; d++) begin
      board.neighbor(x, y, z, d, nx, ny, nz);
      if (!board.written[board.cell_index(nx, ny, nz)])
        send_item(OP_WRITE, nx, ny, nz, fill_label());
    end
  endtask

  // examine where the result rests only on written voxels, else write the voxel
  task automatic probe(input logic [4:0] x, input logic [4:0] y, input logic [4:0] z);
    if (board.examine_safe(x, y, z))
      send_item(OP_EXAMINE, x, y, z, 8'($urandom));
    else
      send_item(OP_WRITE, x, y, z, fill_label());
  endtask

  task automatic random_step();
    logic [4:0] cx, cy, cz, nx, ny, nz;
    int         pick, d;
    pick = $urandom_range(99);
    if (pick < 55) begin
      // grow a blob of the target label, then examine inside and around it
      cx = coord_in(board.size_x);
      cy = coord_in(board.size_y);
      cz = coord_in(board.size_z);
      send_item(OP_WRITE, cx, cy, cz, board.target);
      for (d = 0; d < 6; d++) begin
        board.neighbor(cx, cy, cz, d, nx, ny, nz);
        if ($urandom_range(9) < 7) send_item(OP_WRITE, nx, ny, nz, board.target);
      end
      cover_neighbors(cx, cy, cz);
      probe(cx, cy, cz);
      repeat ($urandom_range(2)) begin
        board.neighbor(cx, cy, cz, int'($urandom_range(5)), nx, ny, nz);
        probe(nx, ny, nz);
      end
    end else if (pick < 75) begin
      // probes only, so the face counter keeps running unless a probe writes
      repeat ($urandom_range(5, 2))
        probe(coord_in(board.size_x), coord_in(board.size_y), coord_in(board.size_z));
    end else if (pick < 95) begin
      if ($urandom_range(1) == 0)
        send_item(OP_WRITE, 5'($urandom), 5'($urandom), 5'($urandom), 8'($urandom));
      else
        probe(5'($urandom), 5'($urandom), 5'($urandom));
    end else begin
      wait_drained();
    end
  endtask

  initial begin : stimulus
    logic [4:0] nx, ny, nz;
    int         d, phase, phase_end, waited;
    board = new;
    set_idle(IDLE_NONE);
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    apply_settings(DIRECTED_LABEL, 6'd32, 6'd32, 6'd32);
    // enclosed voxel: no faces; its neighbor shows all but one side
    send_item(OP_WRITE, 5'd5, 5'd5, 5'd5, DIRECTED_LABEL);
    for (d = 0; d < 6; d++) begin
      board.neighbor(5'd5, 5'd5, 5'd5, d, nx, ny, nz);
      send_item(OP_WRITE, nx, ny, nz, DIRECTED_LABEL);
    end
    send_item(OP_EXAMINE, 5'd5, 5'd5, 5'd5, 8'h00);
    cover_neighbors(5'd6, 5'd5, 5'd5);
    send_item(OP_EXAMINE, 5'd6, 5'd5, 5'd5, 8'hFF);
    // lone voxel: the fill never uses this label, so all six sides show
    send_item(OP_WRITE, 5'd10, 5'd20, 5'd30, DIRECTED_LABEL);
    cover_neighbors(5'd10, 5'd20, 5'd30);
    send_item(OP_EXAMINE, 5'd10, 5'd20, 5'd30, 8'h00);
    send_item(OP_WRITE, 5'd0, 5'd0, 5'd0, DIRECTED_LABEL);
    cover_neighbors(5'd0, 5'd0, 5'd0);
    send_item(OP_EXAMINE, 5'd0, 5'd0, 5'd0, 8'h00);
    send_item(OP_WRITE, 5'd31, 5'd31, 5'd31, DIRECTED_LABEL);
    cover_neighbors(5'd31, 5'd31, 5'd31);
    send_item(OP_EXAMINE, 5'd31, 5'd31, 5'd31, 8'hFF);
    send_item(OP_WRITE, 5'd31, 5'd0, 5'd31, 8'hFF);
    send_item(OP_EXAMINE, 5'd31, 5'd0, 5'd31, 8'h00);
    cover_neighbors(5'd4, 5'd5, 5'd5);
    // shrunk extent: outside emits nothing, inside sees the extent as a wall
    apply_settings(DIRECTED_LABEL, 6'd5, 6'd6, 6'd7);
    send_item(OP_EXAMINE, 5'd5, 5'd5, 5'd5, 8'h00);
    send_item(OP_EXAMINE, 5'd4, 5'd5, 5'd5, 8'h00);
    send_item(OP_EXAMINE, 5'd31, 5'd31, 5'd31, 8'h00);

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       apply_settings(8'h3C, 6'd32, 6'd32, 6'd32);
        1:       apply_settings(8'h00, 6'd63, 6'd1, 6'd32);
        2:       apply_settings(8'hFF, 6'd1, 6'd32, 6'd33);
        3:       apply_settings(8'($urandom), 6'd0, pick_size(), pick_size());
        default: apply_settings(($urandom_range(3) == 0) ? 8'($urandom) : fill_label(),
                                pick_size(), pick_size(), pick_size());
      endcase
      set_idle(idle_mode_t'(phase % 4));
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) random_step();
    end

    in_valid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (board.expected_faces.size() != 0 && waited < END_WAIT);
    repeat (SETTLE_CYCLES) @(posedge clk);
    board.check_drained();
    if (board.failures == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule

FILE: voxel_boundary_quads.f
+incdir+src
src/vbq_pkg.sv
src/voxel_boundary_quads.sv
test/tb_top.sv
